FILE: rtl/source_tokenizer_assert.svh
// Assertion macros for the source tokenizer.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define STT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
// Shared types, constants and byte classification for the source tokenizer.
// No dependencies.
`default_nettype none

package stt_pkg;

    localparam int POS_W      = 16;
    localparam int WIDE_W     = POS_W + 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [15:0]      FIELD_MAX = 16'hFFFF;

    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;

    typedef enum logic [4:0] {
        TOK_IDENT     = 5'd0,
        TOK_INTEGER   = 5'd1,
        TOK_STRING    = 5'd2,
        TOK_ADD       = 5'd3,
        TOK_SUB       = 5'd4,
        TOK_DIV       = 5'd5,
        TOK_MULT      = 5'd6,
        TOK_MOD       = 5'd7,
        TOK_EQUAL     = 5'd8,
        TOK_LBRACE    = 5'd9,
        TOK_RBRACE    = 5'd10,
        TOK_LPAREN    = 5'd11,
        TOK_RPAREN    = 5'd12,
        TOK_COMMA     = 5'd13,
        TOK_DOT       = 5'd14,
        TOK_SEMICOLON = 5'd15,
        TOK_LESS      = 5'd16,
        TOK_GREATER   = 5'd17,
        TOK_NEW_LINE  = 5'd18,
        TOK_UNKNOWN   = 5'd19,
        TOK_EOF       = 5'd20
    } tok_type_t;

    typedef struct packed {
        tok_type_t   token_type;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } token_t;

    typedef struct packed {
        logic               room2;
        logic [LEVEL_W-1:0] level;
    } fifo_stat_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, [8'h09:8'h0D]};
    endfunction

    function automatic tok_type_t punct_type(input logic [7:0] c);
        tok_type_t t;
        case (c)
            CH_PLUS: t = TOK_ADD;
            8'h2D:   t = TOK_SUB;
            CH_SLASH: t = TOK_DIV;
            8'h2A:   t = TOK_MULT;
            8'h25:   t = TOK_MOD;
            8'h3D:   t = TOK_EQUAL;
            8'h7B:   t = TOK_LBRACE;
            8'h7D:   t = TOK_RBRACE;
            8'h28:   t = TOK_LPAREN;
            8'h29:   t = TOK_RPAREN;
            8'h2C:   t = TOK_COMMA;
            8'h2E:   t = TOK_DOT;
            8'h3B:   t = TOK_SEMICOLON;
            8'h3C:   t = TOK_LESS;
            8'h3E:   t = TOK_GREATER;
            CH_NL:   t = TOK_NEW_LINE;
            default: t = TOK_UNKNOWN;
        endcase
        return t;
    endfunction

    // saturate a position-width value to a 16-bit field
    function automatic logic [15:0] clip16(input logic [POS_W-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = {16'b0, v};
        if (wide > WIDE_W'(FIELD_MAX))
            return FIELD_MAX;
        return wide[15:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/stt_scan.sv
// Scan state and per-byte token logic: up to two tokens per transaction.
// Depends on stt_pkg.
`default_nettype none

module stt_scan (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          cmd_eos,
    input  logic [7:0]    byte_in,
    output stt_pkg::token_t tok0,
    output stt_pkg::token_t tok1,
    output logic [1:0]    tok_count
);
    import stt_pkg::*;

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_IDENT   = 7'b0000010,
        M_NUMBER  = 7'b0000100,
        M_SLASH   = 7'b0001000,
        M_COMMENT = 7'b0010000,
        M_STRING  = 7'b0100000,
        M_STRESC  = 7'b1000000
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  tbeg_reg, tbeg_next;
    logic [15:0]       line_reg, line_next;

    logic [POS_W-1:0]  pos_take;
    logic [15:0]       line_take;
    logic [POS_W-1:0]  pend_len;
    logic              va, vb, go_idle;
    token_t            tok_a, tok_b;

    always_comb
    begin
        pos_take  = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        line_take = (byte_in == CH_NL && line_reg != FIELD_MAX) ? line_reg + 16'd1 : line_reg;
        pend_len  = (pos_reg >= tbeg_reg) ? pos_reg - tbeg_reg : '0;

        mode_next = mode_reg;
        pos_next  = pos_reg;
        tbeg_next = tbeg_reg;
        line_next = line_reg;
        va        = 1'b0;
        vb        = 1'b0;
        go_idle   = 1'b0;

        tok_a.token_type   = TOK_IDENT;
        tok_a.start_offset = clip16(tbeg_reg);
        tok_a.token_length = clip16(pend_len);
        tok_a.line_number  = line_reg;
        tok_a.last_of_run  = 1'b1;

        tok_b.token_type   = punct_type(byte_in);
        tok_b.start_offset = clip16(pos_reg);
        tok_b.token_length = clip16(pos_take - pos_reg);
        tok_b.line_number  = line_take;
        tok_b.last_of_run  = 1'b1;

        if (cmd_eos)
        begin
            case (mode_reg)
                M_IDENT:  begin va = 1'b1; tok_a.token_type = TOK_IDENT;   end
                M_NUMBER: begin va = 1'b1; tok_a.token_type = TOK_INTEGER; end
                M_STRING, M_STRESC:
                          begin va = 1'b1; tok_a.token_type = TOK_STRING;  end
                M_SLASH:  begin va = 1'b1; tok_a.token_type = TOK_DIV;     end
                default:  va = 1'b0;
            endcase
            vb                 = 1'b1;
            tok_b.token_type   = TOK_EOF;
            tok_b.token_length = 16'd0;
            tok_b.line_number  = line_reg;
            mode_next          = M_IDLE;
            pos_next           = '0;
            tbeg_next          = '0;
            line_next          = 16'd1;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_letter(byte_in))
                    begin
                        pos_next  = pos_take;
                        line_next = line_take;
                    end
                    else
                    begin
                        va      = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(byte_in))
                    begin
                        pos_next  = pos_take;
                        line_next = line_take;
                    end
                    else
                    begin
                        va               = 1'b1;
                        tok_a.token_type = TOK_INTEGER;
                        go_idle          = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (byte_in == CH_SLASH)
                    begin
                        pos_next  = pos_take;
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        va               = 1'b1;
                        tok_a.token_type = TOK_DIV;
                        go_idle          = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    pos_next  = pos_take;
                    line_next = line_take;
                    if (byte_in == CH_NL)
                    begin
                        va                 = 1'b1;
                        tok_a.token_type   = TOK_NEW_LINE;
                        tok_a.start_offset = clip16(pos_reg);
                        tok_a.token_length = clip16(pos_take - pos_reg);
                        tok_a.line_number  = line_take;
                        tbeg_next          = pos_reg;
                        mode_next          = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    pos_next  = pos_take;
                    line_next = line_take;
                    if (byte_in == CH_QUOTE)
                    begin
                        va                 = 1'b1;
                        tok_a.token_type   = TOK_STRING;
                        tok_a.token_length = clip16(pos_take - tbeg_reg);
                        tok_a.line_number  = line_take;
                        mode_next          = M_IDLE;
                    end
                    else if (byte_in == CH_BACKSLASH)
                        mode_next = M_STRESC;
                end
                M_STRESC:
                begin
                    pos_next  = pos_take;
                    line_next = line_take;
                    mode_next = M_STRING;
                end
                default: go_idle = 1'b1;
            endcase

            if (go_idle)
            begin
                pos_next  = pos_take;
                line_next = line_take;
                mode_next = M_IDLE;
                if (!is_space(byte_in))
                begin
                    tbeg_next = pos_reg;
                    if (is_letter(byte_in))
                        mode_next = M_IDENT;
                    else if (is_digit(byte_in))
                        mode_next = M_NUMBER;
                    else if (byte_in == CH_QUOTE)
                        mode_next = M_STRING;
                    else if (byte_in == CH_SLASH)
                        mode_next = M_SLASH;
                    else
                        vb = 1'b1;
                end
            end
        end

        tok_a.last_of_run = !vb;
        tok0      = va ? tok_a : tok_b;
        tok1      = tok_b;
        tok_count = {1'b0, va} + {1'b0, vb};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            pos_reg  <= '0;
            tbeg_reg <= '0;
            line_reg <= 16'd1;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            tbeg_reg <= tbeg_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/stt_fifo.sv
// Result queue: takes up to two tokens per cycle, releases one per transaction.
// Depends on stt_pkg.
`default_nettype none

module stt_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  stt_pkg::token_t      push0,
    input  stt_pkg::token_t      push1,
    output stt_pkg::token_t      head,
    output logic                 head_valid,
    input  logic                 pop,
    output stt_pkg::fifo_stat_t  stat
);
    import stt_pkg::*;

    token_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_reg, wr_next;
    logic [FIFO_AW-1:0]   rd_reg, rd_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic                 do_pop;

    assign head_valid = (level_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    assign stat.level = level_reg;
    assign stat.room2 = (level_reg <= LEVEL_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + FIFO_AW'(push_count);
        rd_next    = do_pop ? rd_reg + FIFO_AW'(1) : rd_reg;
        level_next = level_reg + LEVEL_W'(push_count) - LEVEL_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem_reg[wr_reg] <= push0;
        if (push_count == 2'd2)
            mem_reg[wr_reg + FIFO_AW'(1)] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/source_tokenizer.sv
// Source tokenizer top level: input register, scan logic and result queue.
// Depends on stt_pkg, stt_scan, stt_fifo and source_tokenizer_assert.svh.
`default_nettype none

// Takes one source byte (or the end marker) per transaction and emits tokens of
// type, start offset, length and line. A byte waits in the input register until
// the queue has room for two tokens, is scanned in a single pass, and its zero,
// one or two tokens enter a four-entry result queue; the input side takes a new
// byte every cycle while the queue has room for two tokens, and tokens leave one
// per cycle while the output is ready. The queue head drives the output ports
// directly. The end marker flushes any pending token, emits an end-of-file token
// and returns the scanner to its reset state.
module source_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
    input  logic        s_axis_tuser,   // [0] command (1 = end of source)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] start_offset, [31:16] token_length,
                                        // [47:32] line_number
    output logic [4:0]  m_axis_tuser,   // [4:0] token_type
    output logic        m_axis_tlast    // last_of_run
);
    import stt_pkg::*;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        fire;
    logic        load;
    token_t      tok0, tok1, head;
    logic [1:0]  tok_count;
    logic [1:0]  push_count;
    fifo_stat_t  fifo_stat;

    assign fire          = in_valid_reg && fifo_stat.room2;
    assign s_axis_tready = !in_valid_reg || fifo_stat.room2;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign push_count    = fire ? tok_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    stt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .cmd_eos   (in_cmd_reg),
        .byte_in   (in_byte_reg),
        .tok0      (tok0),
        .tok1      (tok1),
        .tok_count (tok_count)
    );

    stt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (tok0),
        .push1      (tok1),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .pop        (m_axis_tready),
        .stat       (fifo_stat)
    );

    assign m_axis_tdata = {head.line_number, head.token_length, head.start_offset};
    assign m_axis_tuser = head.token_type;
    assign m_axis_tlast = head.last_of_run;

`include "source_tokenizer_assert.svh"

    `STT_ASSERT(a_fifo_bound, fifo_stat.level <= LEVEL_W'(FIFO_DEPTH), "result queue overflow")
    `STT_ASSERT_IMPL(a_eos_gives_eof, fire && in_cmd_reg, tok_count != 2'd0 && tok1.token_type == TOK_EOF, "end marker without eof token")
    `STT_ASSERT_IMPL(a_pair_last, tok_count == 2'd2, !tok0.last_of_run && tok1.last_of_run, "wrong last flag on token pair")
    `STT_ASSERT_IMPL(a_line_nonzero, m_axis_tvalid, m_axis_tdata[47:32] != 16'd0, "line number zero on output")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for source_tokenizer: byte stream in, tokens out.
// Holds its own token predictor and scoreboard; needs stt_pkg and the block.
// Directed corner cases, random programs, then a cut-off tail.
module testbench;

    import stt_pkg::*;

    localparam int GAP_PCT        = 37;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    localparam int DRAIN_CYCLES   = 16;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_STRING,
        SCAN_STRESC
    } scan_mode_t;

    class token_scoreboard;
        scan_mode_t       mode;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] tok_start;
        logic [15:0]      line;
        token_t           expected_tokens[$];
        token_t           step_tokens[$];
        int               errors;

        function new();
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode      = SCAN_IDLE;
            pos       = '0;
            tok_start = '0;
            line      = 16'd1;
        endfunction

        function int waiting();
            return expected_tokens.size();
        endfunction

        function logic letter_byte(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
        endfunction

        function logic digit_byte(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function logic blank_byte(logic [7:0] c);
            return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function tok_type_t punct_token(logic [7:0] c);
            case (c)
                "+":     return TOK_ADD;
                "-":     return TOK_SUB;
                "/":     return TOK_DIV;
                "*":     return TOK_MULT;
                "%":     return TOK_MOD;
                "=":     return TOK_EQUAL;
                "{":     return TOK_LBRACE;
                "}":     return TOK_RBRACE;
                "(":     return TOK_LPAREN;
                ")":     return TOK_RPAREN;
                ",":     return TOK_COMMA;
                ".":     return TOK_DOT;
                ";":     return TOK_SEMICOLON;
                "<":     return TOK_LESS;
                ">":     return TOK_GREATER;
                default: return TOK_UNKNOWN;
            endcase
        endfunction

        function logic [15:0] to_field(logic [POS_W-1:0] v);
            return (v > POS_W'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
        endfunction

        function void advance(logic [7:0] c);
            if (pos != POS_MAX)
                pos++;
            if (c == CH_NL && line != FIELD_MAX)
                line++;
        endfunction

        function void push_token(tok_type_t t, logic [POS_W-1:0] start, logic [POS_W-1:0] len);
            token_t tk;
            tk.token_type   = t;
            tk.start_offset = to_field(start);
            tk.token_length = to_field(len);
            tk.line_number  = line;
            tk.last_of_run  = 1'b0;
            step_tokens.push_back(tk);
        endfunction

        function void push_pending(tok_type_t t);
            push_token(t, tok_start, (pos >= tok_start) ? pos - tok_start : '0);
        endfunction

        // byte seen between tokens: skip it, open a token, or emit it whole
        function void open_token(logic [7:0] c);
            if (blank_byte(c)) begin
                advance(c);
            end else begin
                tok_start = pos;
                advance(c);
                if (letter_byte(c))
                    mode = SCAN_IDENT;
                else if (digit_byte(c))
                    mode = SCAN_NUMBER;
                else if (c == CH_QUOTE)
                    mode = SCAN_STRING;
                else if (c == CH_SLASH)
                    mode = SCAN_SLASH;
                else
                    push_pending(punct_token(c));
            end
        endfunction

        function void note_byte(logic eos, logic [7:0] c);
            token_t tk;
            step_tokens.delete();
            if (eos) begin
                case (mode)
                    SCAN_IDENT:               push_pending(TOK_IDENT);
                    SCAN_NUMBER:              push_pending(TOK_INTEGER);
                    SCAN_STRING, SCAN_STRESC: push_pending(TOK_STRING);
                    SCAN_SLASH:               push_pending(TOK_DIV);
                    default:                  ;
                endcase
                push_token(TOK_EOF, pos, '0);
                clear_scan();
            end else begin
                case (mode)
                    SCAN_IDENT:
                        if (letter_byte(c)) begin
                            advance(c);
                        end else begin
                            push_pending(TOK_IDENT);
                            mode = SCAN_IDLE;
                            open_token(c);
                        end
                    SCAN_NUMBER:
                        if (digit_byte(c)) begin
                            advance(c);
                        end else begin
                            push_pending(TOK_INTEGER);
                            mode = SCAN_IDLE;
                            open_token(c);
                        end
                    SCAN_SLASH:
                        if (c == CH_SLASH) begin
                            advance(c);
                            mode = SCAN_COMMENT;
                        end else begin
                            push_pending(TOK_DIV);
                            mode = SCAN_IDLE;
                            open_token(c);
                        end
                    SCAN_COMMENT:
                        if (c == CH_NL) begin
                            tok_start = pos;
                            advance(c);
                            push_pending(TOK_NEW_LINE);
                            mode = SCAN_IDLE;
                        end else begin
                            advance(c);
                        end
                    SCAN_STRING: begin
                        advance(c);
                        if (c == CH_QUOTE) begin
                            push_pending(TOK_STRING);
                            mode = SCAN_IDLE;
                        end else if (c == CH_BACKSLASH) begin
                            mode = SCAN_STRESC;
                        end
                    end
                    SCAN_STRESC: begin
                        advance(c);
                        mode = SCAN_STRING;
                    end
                    default:
                        open_token(c);
                endcase
            end
            if (step_tokens.size() > 0) begin
                tk = step_tokens.pop_back();
                tk.last_of_run = 1'b1;
                step_tokens.push_back(tk);
            end
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_token(token_t got);
            token_t want;
            if (expected_tokens.size() == 0) begin
                errors++;
                $display("%0t unexpected token: expected none, got type %0d start %0d len %0d",
                         $time, got.token_type, got.start_offset, got.token_length);
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_type !== want.token_type)
                report("token_type", 16'(want.token_type), 16'(got.token_type));
            if (got.start_offset !== want.start_offset)
                report("start_offset", want.start_offset, got.start_offset);
            if (got.token_length !== want.token_length)
                report("token_length", want.token_length, got.token_length);
            if (got.line_number !== want.line_number)
                report("line_number", want.line_number, got.line_number);
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    token_t          out_token;
    token_scoreboard sb;
    bit              gaps_on;
    bit              hold_pending;
    int              sent_items;
    int              quiet_cycles = 0;

    source_tokenizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    assign out_token = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                        m_axis_tdata[47:32], m_axis_tlast};

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_token(out_token);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // token sink; a requested hold-off lets the result queue fill up
    initial
    begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
            end
        end
    end

    task automatic send_item(input logic eos, input logic [7:0] c);
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= eos;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic send_eof();
        send_item(1'b1, 8'($urandom_range(255)));
    endtask

    // mostly well-formed lexemes with random content, some noise and end markers
    task automatic send_random_program(input int target);
        int         kind;
        int         n;
        int         r;
        logic [7:0] c;
        string      punct;
        punct = "+-/*%={}(),.;<>";
        while (sent_items < target) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    r = $urandom_range(52);
                    c = (r < 26) ? 8'("a" + r) : (r < 52) ? 8'("A" + r - 26) : CH_UNDERSCORE;
                    send_item(1'b0, c);
                end
            end else if (kind < 31) begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(1'b0, 8'(CH_ZERO + $urandom_range(9)));
            end else if (kind < 41) begin
                send_item(1'b0, CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(4) == 0)
                        send_item(1'b0, CH_BACKSLASH);
                    send_item(1'b0, 8'($urandom_range(255)));
                end
                if ($urandom_range(9) != 0)
                    send_item(1'b0, CH_QUOTE);
            end else if (kind < 49) begin
                send_text("//");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    c = 8'($urandom_range(255));
                    send_item(1'b0, (c == CH_NL) ? CH_SPACE : c);
                end
                send_item(1'b0, CH_NL);
            end else if (kind < 64) begin
                send_item(1'b0, punct[$urandom_range(punct.len() - 1)]);
            end else if (kind < 78) begin
                r = $urandom_range(5);
                send_item(1'b0, (r == 5) ? CH_SPACE : 8'(9 + r));
            end else if (kind < 90) begin
                send_item(1'b0, 8'($urandom_range(255)));
            end else if (kind < 95) begin
                send_item(1'b0, CH_SLASH);
                send_item(1'b0, 8'($urandom_range(255)));
            end else begin
                send_eof();
            end
        end
        send_eof();
    endtask

    initial
    begin
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        gaps_on      = 1'b1;
        hold_pending = 1'b0;
        sent_items   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty source; ident cut by digit; lone slash; comment; escaped quote
        send_eof();
        send_text("_Zz9/x//q\n\"\\\"\"");
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h7F);
        // string cut off after a backslash, then end inside a comment
        send_text("\"a\\");
        send_eof();
        send_text("//");
        send_eof();

        gaps_on      = 1'b0;
        hold_pending = 1'b1;
        send_random_program(sent_items + 300);
        gaps_on      = 1'b1;
        hold_pending = 1'b1;
        send_random_program(sent_items + 800);

        // mixed tail ending in a cut-off string
        send_text("ab 12\"q\\");
        send_eof();
        s_axis_tvalid <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_fifo.sv
rtl/source_tokenizer.sv
tb/sv/testbench.sv
